/* hdl/acfp_pkg.sv */
// Shared constants, types and functions for the ASCII command frame parser.
package acfp_pkg;

	localparam int unsigned PosW = 5;
	localparam int unsigned NumW = 16;
	localparam int unsigned CodeW = 3;

	localparam logic [PosW-1:0] POS_IDLE      = 5'd19;
	localparam logic [PosW-1:0] POS_LAST      = 5'd18;
	localparam logic [PosW-1:0] POS_CMD_LO    = 5'd1;
	localparam logic [PosW-1:0] POS_CMD_HI    = 5'd4;
	localparam logic [PosW-1:0] POS_TGT_LO    = 5'd6;
	localparam logic [PosW-1:0] POS_TGT_HI    = 5'd9;
	localparam logic [PosW-1:0] POS_HIGH_LO   = 5'd11;
	localparam logic [PosW-1:0] POS_HIGH_HI   = 5'd14;
	localparam logic [PosW-1:0] POS_LOW_LO    = 5'd15;

	localparam logic [CodeW-1:0] CMD_NONE = 3'd0;
	localparam logic [CodeW-1:0] CMD_SCPV = 3'd1;
	localparam logic [CodeW-1:0] CMD_GCPV = 3'd2;
	localparam logic [CodeW-1:0] CMD_SDSM = 3'd3;
	localparam logic [CodeW-1:0] CMD_GDST = 3'd4;
	localparam logic [CodeW-1:0] CMD_CLED = 3'd5;

	localparam logic [31:0] NAME_SCPV = "SCPV";
	localparam logic [31:0] NAME_GCPV = "GCPV";
	localparam logic [31:0] NAME_SDSM = "SDSM";
	localparam logic [31:0] NAME_GDST = "GDST";
	localparam logic [31:0] NAME_CLED = "CLED";

	localparam logic [NumW-1:0] ASCII_ZERO = 16'd48;

	typedef struct packed {
		logic             fire;
		logic [CodeW-1:0] code;
		logic [NumW-1:0]  target;
		logic [NumW-1:0]  high;
		logic [NumW-1:0]  low;
	} acfp_res_t;

	// acc*10 + (b - '0'), wrapped to 16 bits
	function automatic logic [NumW-1:0] fold_digit(input logic [NumW-1:0] acc,
			input logic [7:0] b);
		logic [NumW-1:0] times10;
		times10 = (acc << 3) + (acc << 1);
		return times10 + {8'd0, b} - ASCII_ZERO;
	endfunction

	function automatic logic [CodeW-1:0] match_name(input logic [31:0] chars);
		logic [CodeW-1:0] code;
		unique case (chars)
			NAME_SCPV: code = CMD_SCPV;
			NAME_GCPV: code = CMD_GCPV;
			NAME_SDSM: code = CMD_SDSM;
			NAME_GDST: code = CMD_GDST;
			NAME_CLED: code = CMD_CLED;
			default:   code = CMD_NONE;
		endcase
		return code;
	endfunction

endpackage

/* hdl/acfp_frame.sv */
// Frame position tracking, command capture and decimal field accumulation.
module acfp_frame
	import acfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	input  logic            frame_start,
	output acfp_res_t       res
);

	logic [PosW-1:0] pos_q;
	logic [31:0]     cmd_q;
	logic [NumW-1:0] tgt_q;
	logic [NumW-1:0] hi_q;
	logic [NumW-1:0] lo_q;
	logic [PosW-1:0] pos_nx;
	logic            active;

	assign pos_nx = pos_q + 5'd1;
	assign active = (pos_q < POS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			cmd_q <= '0;
			tgt_q <= '0;
			hi_q  <= '0;
			lo_q  <= '0;
		end else if (step) begin
			if (frame_start) begin
				pos_q <= '0;
				cmd_q <= '0;
				tgt_q <= '0;
				hi_q  <= '0;
				lo_q  <= '0;
			end else if (active) begin
				case (pos_nx) inside
					[POS_CMD_LO:POS_CMD_HI]:   cmd_q <= {cmd_q[23:0], rx_byte};
					[POS_TGT_LO:POS_TGT_HI]:   tgt_q <= fold_digit(tgt_q, rx_byte);
					[POS_HIGH_LO:POS_HIGH_HI]: hi_q  <= fold_digit(hi_q, rx_byte);
					[POS_LOW_LO:POS_LAST]:     lo_q  <= fold_digit(lo_q, rx_byte);
					default: ;
				endcase
				pos_q <= (pos_nx == POS_LAST) ? POS_IDLE : pos_nx;
			end
		end
	end

	assign res.fire   = step && !frame_start && active && (pos_nx == POS_LAST);
	assign res.code   = match_name(cmd_q);
	assign res.target = tgt_q;
	assign res.high   = hi_q;
	assign res.low    = fold_digit(lo_q, rx_byte);

endmodule

/* hdl/ascii_command_frame_parser_core.sv */
// Top level of the ASCII command frame parser: input stage, frame logic, result register.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   rx_byte, frame_start
//  out      out_valid / out_ready command_code, target_number, high_number, low_number
//
// One word per cycle sustained while no stalled result holds the input stage.
// Words pass an input register, then frame logic updates state and loads the result register.
// The input stage holds only while a result waits in the output register with out_ready low.
// Reset empties both stages and leaves the frame logic idle until a frame start.
module ascii_command_frame_parser_core
	import acfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              rx_byte,
	input  logic                    frame_start,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CodeW-1:0]        command_code,
	output logic signed [NumW-1:0]  target_number,
	output logic signed [NumW-1:0]  high_number,
	output logic signed [NumW-1:0]  low_number
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            start_s1;
	logic            adv_s1;
	acfp_res_t       res;

	logic            out_valid_q;
	logic [CodeW-1:0] code_q;
	logic [NumW-1:0] tgt_q;
	logic [NumW-1:0] hi_q;
	logic [NumW-1:0] lo_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	acfp_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			code_q <= res.code;
			tgt_q  <= res.target;
			hi_q   <= res.high;
			lo_q   <= res.low;
		end
	end

	assign out_valid     = out_valid_q;
	assign command_code  = code_q;
	assign target_number = $signed(tgt_q);
	assign high_number   = $signed(hi_q);
	assign low_number    = $signed(lo_q);

endmodule

/* hdl/acfp_checker.sv */
// Port-level checks for the ASCII command frame parser, bound to the top level.
module acfp_checker
	import acfp_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    frame_start,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [CodeW-1:0]        command_code,
	input logic signed [NumW-1:0]  target_number,
	input logic signed [NumW-1:0]  high_number,
	input logic signed [NumW-1:0]  low_number
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command_code)
			&& $stable(target_number) && $stable(high_number) && $stable(low_number))
		else $error("result changed while stalled");

	// a new result follows a plain data word taken through the input handshake
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && !frame_start, 2))
		else $error("result without a preceding data word");

	// an empty output register never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output empty");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command_code <= CMD_CLED))
		else $error("command code out of range");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind ascii_command_frame_parser_core acfp_checker u_acfp_checker (.*);
